### sv/ccr_pkg.sv
// ----------------------------------------------------------------------------
// Condition-code unit package
// Types and constants shared by the condition-code ALU, its condition
// evaluator and the top level.
// ----------------------------------------------------------------------------
package ccr_pkg;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_CMP  = 3'd2,
      OP_TEST = 3'd3,
      OP_LOAD = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_WORD = 2'd1,
      SIZE_LONG = 2'd2
   } size_type;

   typedef enum logic [3:0] {
      COND_T  = 4'd0,
      COND_F  = 4'd1,
      COND_HI = 4'd2,
      COND_LS = 4'd3,
      COND_CC = 4'd4,
      COND_CS = 4'd5,
      COND_NE = 4'd6,
      COND_EQ = 4'd7,
      COND_VC = 4'd8,
      COND_VS = 4'd9,
      COND_PL = 4'd10,
      COND_MI = 4'd11,
      COND_GE = 4'd12,
      COND_LT = 4'd13,
      COND_GT = 4'd14,
      COND_LE = 4'd15
   } cond_type;

   localparam int FLAG_C = 0;
   localparam int FLAG_V = 1;
   localparam int FLAG_Z = 2;
   localparam int FLAG_N = 3;
   localparam int FLAG_X = 4;

   localparam logic [4:0] FLAG_MASK = 5'h1F;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] src_operand;
      logic [31:0] dst_operand;
      logic [1:0]  size_code;
      logic        use_extend;
      logic        sticky_zero;
      logic [3:0]  condition;
   } req_word_type;

   typedef struct packed {
      logic [31:0] result;
      logic [4:0]  flags;
      logic        condition_true;
   } alu_out_type;

endpackage

### sv/ccr_cond.sv
// ----------------------------------------------------------------------------
// Condition evaluator
// Evaluates one of the sixteen standard conditions on the current flags.
// ----------------------------------------------------------------------------
module ccr_cond (
   input  logic [4:0] flags,
   input  logic [3:0] condition,
   output logic       cond_true
);
   import ccr_pkg::*;

   logic n;
   logic z;
   logic v;
   logic c;

   assign n = flags[FLAG_N];
   assign z = flags[FLAG_Z];
   assign v = flags[FLAG_V];
   assign c = flags[FLAG_C];

   always_comb begin
      case (condition)
         COND_T:  cond_true = 1'b1;
         COND_F:  cond_true = 1'b0;
         COND_HI: cond_true = !c && !z;
         COND_LS: cond_true = c || z;
         COND_CC: cond_true = !c;
         COND_CS: cond_true = c;
         COND_NE: cond_true = !z;
         COND_EQ: cond_true = z;
         COND_VC: cond_true = !v;
         COND_VS: cond_true = v;
         COND_PL: cond_true = !n;
         COND_MI: cond_true = n;
         COND_GE: cond_true = (n == v);
         COND_LT: cond_true = (n != v);
         COND_GT: cond_true = (n == v) && !z;
         COND_LE: cond_true = (n != v) || z;
         default: cond_true = 1'b0;
      endcase
   end

endmodule

### sv/ccr_alu.sv
// ----------------------------------------------------------------------------
// Condition-code ALU
// Computes the sum or difference of one word and the flags that follow
// from it and the flags held; also tests a condition or loads flags.
// ----------------------------------------------------------------------------
module ccr_alu (
   input  ccr_pkg::req_word_type req_word,
   input  logic [4:0]            flags_cur,
   output ccr_pkg::alu_out_type  alu_out
);
   import ccr_pkg::*;

   logic [31:0] mask;
   logic [31:0] sign;
   logic [31:0] s;
   logic [31:0] t;
   logic        x_in;
   logic        sub_x;
   logic [32:0] sum_wide;
   logic [32:0] diff_wide;
   logic [31:0] sum_r;
   logic [31:0] diff_r;
   logic        carry;
   logic        borrow;
   logic        v_add;
   logic        v_sub;
   logic        z_sticky_add;
   logic        z_sticky_sub;
   logic        cond_true;

   always_comb begin
      case (req_word.size_code)
         SIZE_BYTE: begin
            mask = 32'h0000_00FF;
            sign = 32'h0000_0080;
         end
         SIZE_WORD: begin
            mask = 32'h0000_FFFF;
            sign = 32'h0000_8000;
         end
         default: begin
            mask = 32'hFFFF_FFFF;
            sign = 32'h8000_0000;
         end
      endcase
   end

   assign s     = req_word.src_operand & mask;
   assign t     = req_word.dst_operand & mask;
   assign x_in  = req_word.use_extend & flags_cur[FLAG_X];
   assign sub_x = (req_word.op == OP_SUB) ? x_in : 1'b0;

   assign sum_wide  = {1'b0, s} + {1'b0, t} + {32'd0, x_in};
   assign diff_wide = {1'b0, t} - {1'b0, s} - {32'd0, sub_x};
   assign sum_r     = sum_wide[31:0] & mask;
   assign diff_r    = diff_wide[31:0] & mask;

   assign carry  = |(sum_wide & ~{1'b0, mask});
   assign borrow = diff_wide[32];
   assign v_add  = |(~(s ^ t) & (s ^ sum_r) & sign);
   assign v_sub  = |((s ^ t) & (t ^ diff_r) & sign);

   assign z_sticky_add = req_word.sticky_zero ? (flags_cur[FLAG_Z] && (sum_r == 32'd0))
                                              : (sum_r == 32'd0);
   assign z_sticky_sub = req_word.sticky_zero ? (flags_cur[FLAG_Z] && (diff_r == 32'd0))
                                              : (diff_r == 32'd0);

   ccr_cond u_cond (
      .flags     (flags_cur),
      .condition (req_word.condition),
      .cond_true (cond_true)
   );

   always_comb begin
      alu_out.result         = 32'd0;
      alu_out.flags          = flags_cur;
      alu_out.condition_true = 1'b0;
      case (req_word.op)
         OP_ADD: begin
            alu_out.result = sum_r;
            alu_out.flags[FLAG_X] = carry;
            alu_out.flags[FLAG_N] = |(sum_r & sign);
            alu_out.flags[FLAG_Z] = z_sticky_add;
            alu_out.flags[FLAG_V] = v_add;
            alu_out.flags[FLAG_C] = carry;
         end
         OP_SUB: begin
            alu_out.result        = diff_r;
            alu_out.flags[FLAG_X] = borrow;
            alu_out.flags[FLAG_N] = |(diff_r & sign);
            alu_out.flags[FLAG_Z] = z_sticky_sub;
            alu_out.flags[FLAG_V] = v_sub;
            alu_out.flags[FLAG_C] = borrow;
         end
         OP_CMP: begin
            alu_out.result        = diff_r;
            alu_out.flags[FLAG_N] = |(diff_r & sign);
            alu_out.flags[FLAG_Z] = (diff_r == 32'd0);
            alu_out.flags[FLAG_V] = v_sub;
            alu_out.flags[FLAG_C] = borrow;
         end
         OP_TEST: begin
            alu_out.condition_true = cond_true;
         end
         OP_LOAD: begin
            alu_out.flags = req_word.src_operand[4:0] & FLAG_MASK;
         end
         default: begin
            alu_out.result = 32'd0;
         end
      endcase
   end

endmodule

### sv/alu_condition_codes_core.sv
// ----------------------------------------------------------------------------
// Condition-code unit, top level
// Holds the X, N, Z, V and C flags and performs add, subtract, compare,
// condition test and flag load on one word per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_ready and the req_ fields) carries one
//   operation per word. The response channel (rsp_valid, rsp_ready and the
//   rsp_ fields) returns one word per request, in order: the masked result,
//   the flags after the operation and the outcome of a condition test.
//   A request word is captured in an input register; from there the ALU
//   works on it against the flag register, and the flags and the response
//   are written together into the flag and output registers. The response
//   thus passes the input register and then the output register, and the
//   unit takes a new word in every cycle while rsp_ready is high.
//   Each operation sees the flags left by the one before it, since the flag
//   register is updated in the same edge that moves a word to the output.
//   When the receiver holds rsp_ready low, the response word stays put, one
//   further request is held in the input register and req_ready then falls.
//   A synchronous reset clears the flags to zero and empties both registers.
// ----------------------------------------------------------------------------
module alu_condition_codes_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_src_operand,
   input  logic [31:0] req_dst_operand,
   input  logic [1:0]  req_size_code,
   input  logic        req_use_extend,
   input  logic        req_sticky_zero,
   input  logic [3:0]  req_condition,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result,
   output logic [4:0]  rsp_flags,
   output logic        rsp_condition_true
);
   import ccr_pkg::*;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_word_type s1_word_ff;
   req_word_type s1_word_in;
   logic [4:0]   flags_ff;
   logic [4:0]   flags_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   alu_out_type  rsp_word_ff;
   alu_out_type  rsp_word_in;
   alu_out_type  alu_out;
   logic         req_accept;
   logic         s1_advance;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   ccr_alu u_alu (
      .req_word  (s1_word_ff),
      .flags_cur (flags_ff),
      .alu_out   (alu_out)
   );

   always_comb begin
      s1_word_in.op          = req_op;
      s1_word_in.src_operand = req_src_operand;
      s1_word_in.dst_operand = req_dst_operand;
      s1_word_in.size_code   = req_size_code;
      s1_word_in.use_extend  = req_use_extend;
      s1_word_in.sticky_zero = req_sticky_zero;
      s1_word_in.condition   = req_condition;
   end

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign flags_in     = s1_advance ? alu_out.flags : flags_ff;
   assign rsp_word_in  = s1_advance ? alu_out : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= 5'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_word_ff <= s1_word_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_word_ff.result;
   assign rsp_flags          = rsp_word_ff.flags;
   assign rsp_condition_true = rsp_word_ff.condition_true;

endmodule

### sv/ccr_checker.sv
// ----------------------------------------------------------------------------
// Condition-code unit checker
// Watches the ports of the top level for reset behaviour, flow control and
// the consistency of response words.
// ----------------------------------------------------------------------------
module ccr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result,
   input logic [4:0]  rsp_flags,
   input logic        rsp_condition_true
);

   a_reset_empties_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("Request not ready after reset.");

   a_empty_output_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Request stalled while the output is empty.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result) && $stable(rsp_flags)
         && $stable(rsp_condition_true))
      else $error("Stalled response word changed.");

   a_test_has_no_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_condition_true |-> rsp_result == 32'd0)
      else $error("Condition test returned a nonzero result.");

endmodule

bind alu_condition_codes_core ccr_checker u_ccr_checker (.*);
